// ===== src/wstd_pkg.sv =====
// wstd_pkg: shared types and constants for the work-stealing task deque.
// Payload structs, mode codes, controller states, control/status bundles.
// No dependencies.
package wstd_pkg;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_STEAL = 2'd1,
        MODE_DRAIN = 2'd2,
        MODE_ALL   = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] task_word;
        logic [6:0]  take_limit;
        logic [6:0]  keep_floor;
    } t_in_item;

    typedef struct packed {
        logic        item_valid;
        logic [31:0] out_task;
        logic        last;
        logic [6:0]  moved_count;
        logic [6:0]  occupancy;
        logic        status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_TRIM,
        S_READ,
        S_EMIT,
        S_NULL
    } t_state;

    typedef struct packed {
        logic load_cmd;
        logic plan;
        logic trim;
        logic pop;
        logic emit_push;
        logic emit_task;
        logic emit_null;
    } t_ctl_cmd;

    typedef struct packed {
        logic is_push;
        logic trim_zero;
        logic left_zero;
        logic out_free;
    } t_dp_stat;

    // steal target thresholds
    localparam int STEAL_BIG = 64;
    localparam int STEAL_MID = 8;

    // reciprocal multiply for x/5 and x/3
    localparam int DIV5_MUL   = 3277;
    localparam int DIV5_SHIFT = 14;
    localparam int DIV3_MUL   = 2731;
    localparam int DIV3_SHIFT = 13;

endpackage

// ===== src/wstd_ctrl.sv =====
// wstd_ctrl: command sequencer for the task deque.
// Walks plan, trim, read, emit and null steps; drives wstd_dp through t_ctl_cmd.
// Depends on wstd_pkg.
module wstd_ctrl
    import wstd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_ctl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_cmd = 1'b1;
                    n_state        = S_PLAN;
                end
            end
            S_PLAN: begin
                o_cmd.plan = 1'b1;
                if (!i_stat.is_push) begin
                    n_state = S_TRIM;
                end else if (i_stat.out_free) begin
                    o_cmd.emit_push = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_TRIM: begin
                o_cmd.trim = 1'b1;
                n_state    = i_stat.trim_zero ? S_NULL : S_READ;
            end
            S_READ: begin
                o_cmd.pop = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_task = 1'b1;
                    n_state         = i_stat.left_zero ? S_IDLE : S_READ;
                end
            end
            S_NULL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_null = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/wstd_dp.sv =====
// wstd_dp: datapath of the task deque: circular task store, pointers,
// steal amount arithmetic, move counters and the output register.
// Depends on wstd_pkg.
module wstd_dp
    import wstd_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int TASK_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  logic      i_out_ready,
    input  t_ctl_cmd  i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int AW  = $clog2(DEPTH);
    localparam int AW1 = AW + 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int XW  = ((CW > 7) ? CW : 7) + 1;
    localparam int PW  = CW + 14;

    logic [TASK_WIDTH-1:0] r_mem [DEPTH];
    logic [TASK_WIDTH-1:0] r_rd;

    t_in_item  r_cmd;
    logic [AW-1:0] r_front;
    logic [CW-1:0] r_held;
    logic [CW-1:0] r_target;
    logic          r_elig;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_left;
    logic [CW-1:0] r_final;
    logic          r_out_valid;
    t_out_item     r_out;

    logic          out_free;
    logic          full;
    logic          wr_en;
    logic [AW1-1:0] push_sum;
    logic [AW1-1:0] back_sum;
    logic [AW1-1:0] front_sum;
    logic [AW-1:0]  push_slot;
    logic [AW-1:0]  back_slot;
    logic [AW-1:0]  front_next;
    logic [AW-1:0]  rd_slot;
    logic [63:0]    wr_ext;
    logic [63:0]    rd_ext;
    logic [PW-1:0]  prod5;
    logic [PW-1:0]  prod3;
    logic [CW-1:0]  n_target;
    logic [XW-1:0]  room;
    logic [XW-1:0]  n_count_x;
    logic [CW-1:0]  n_count;
    logic [CW-1:0]  held_plus;

    assign out_free = !r_out_valid || i_out_ready;
    assign full     = (r_held == CW'(DEPTH));
    assign wr_en    = i_cmd.emit_push && !full;

    // circular slot arithmetic
    assign push_sum  = AW1'(r_front) + AW1'(r_held);
    assign back_sum  = push_sum - AW1'(1);
    assign front_sum = AW1'(r_front) + AW1'(1);
    assign push_slot  = (push_sum >= AW1'(DEPTH)) ? AW'(push_sum - AW1'(DEPTH)) : AW'(push_sum);
    assign back_slot  = (back_sum >= AW1'(DEPTH)) ? AW'(back_sum - AW1'(DEPTH)) : AW'(back_sum);
    assign front_next = (front_sum >= AW1'(DEPTH)) ? AW'(front_sum - AW1'(DEPTH))
                                                   : AW'(front_sum);
    assign rd_slot    = (r_cmd.mode == MODE_STEAL) ? back_slot : r_front;

    assign wr_ext    = 64'(r_cmd.task_word);
    assign rd_ext    = 64'(r_rd);
    assign held_plus = r_held + CW'(1);

    // steal target: 2/5 of occupancy, 1/3, or 1
    assign prod5 = PW'({r_held, 1'b0}) * PW'(DIV5_MUL);
    assign prod3 = PW'(r_held) * PW'(DIV3_MUL);

    always_comb begin
        priority if (32'(r_held) >= 32'(STEAL_BIG)) begin
            n_target = prod5[DIV5_SHIFT +: CW];
        end else if (32'(r_held) >= 32'(STEAL_MID)) begin
            n_target = prod3[DIV3_SHIFT +: CW];
        end else begin
            n_target = CW'(1);
        end
        if (n_target == '0) begin
            n_target = CW'(1);
        end
    end

    always_comb begin
        room      = XW'(r_held) - XW'(r_cmd.keep_floor);
        n_count_x = '0;
        unique case (r_cmd.mode)
            MODE_STEAL: begin
                if (r_elig) begin
                    n_count_x = XW'(r_target);
                    if (room < n_count_x) begin
                        n_count_x = room;
                    end
                    if (XW'(r_cmd.take_limit) < n_count_x) begin
                        n_count_x = XW'(r_cmd.take_limit);
                    end
                end
            end
            MODE_DRAIN: begin
                n_count_x = (XW'(r_cmd.take_limit) < XW'(r_held)) ? XW'(r_cmd.take_limit)
                                                                   : XW'(r_held);
            end
            MODE_ALL: begin
                n_count_x = XW'(r_held);
            end
            MODE_PUSH: begin
                n_count_x = '0;
            end
            default: begin
                n_count_x = '0;
            end
        endcase
        n_count = CW'(n_count_x);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cmd) begin
            r_cmd <= i_in_item;
        end
        if (i_cmd.plan) begin
            r_target <= n_target;
            r_elig   <= (r_cmd.take_limit != '0) &&
                        (XW'(r_held) > XW'(r_cmd.keep_floor));
        end
        if (i_cmd.trim) begin
            r_final <= r_held - n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[push_slot] <= wr_ext[TASK_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_rd <= r_mem[rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_held  <= '0;
            r_count <= '0;
            r_left  <= '0;
        end else begin
            if (wr_en) begin
                r_held <= held_plus;
            end
            if (i_cmd.trim) begin
                r_count <= n_count;
                r_left  <= n_count;
            end
            if (i_cmd.pop) begin
                r_held <= r_held - CW'(1);
                r_left <= r_left - CW'(1);
                if (r_cmd.mode != MODE_STEAL) begin
                    r_front <= front_next;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_push || i_cmd.emit_task || i_cmd.emit_null) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.emit_push) begin
            r_out.item_valid  <= 1'b0;
            r_out.out_task    <= '0;
            r_out.last        <= 1'b1;
            r_out.moved_count <= '0;
            r_out.occupancy   <= full ? 7'(r_held) : 7'(held_plus);
            r_out.status      <= full;
        end else if (i_cmd.emit_task) begin
            r_out.item_valid  <= 1'b1;
            r_out.out_task    <= rd_ext[31:0];
            r_out.last        <= (r_left == '0);
            r_out.moved_count <= 7'(r_count);
            r_out.occupancy   <= 7'(r_final);
            r_out.status      <= 1'b0;
        end else if (i_cmd.emit_null) begin
            r_out.item_valid  <= 1'b0;
            r_out.out_task    <= '0;
            r_out.last        <= 1'b1;
            r_out.moved_count <= '0;
            r_out.occupancy   <= 7'(r_held);
            r_out.status      <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_item       = r_out;
    assign o_stat.is_push   = (r_cmd.mode == MODE_PUSH);
    assign o_stat.trim_zero = (n_count == '0);
    assign o_stat.left_zero = (r_left == '0);
    assign o_stat.out_free  = out_free;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_held) <= 32'(DEPTH))
        else $error("occupancy above depth");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= r_count)
        else $error("remaining moves exceed planned count");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_held != '0) && (r_left != '0))
        else $error("pop from empty deque");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |=> r_held == $past(r_held) - CW'(1))
        else $error("pop did not decrement occupancy");

endmodule

// ===== src/work_steal_task_deque.sv =====
// work_steal_task_deque: top level of the bounded work-stealing task deque.
// Instantiates wstd_ctrl and wstd_dp; depends on wstd_pkg.
//
//   channel | valid      | ready       | payload
//   --------+------------+-------------+-----------------------
//   command | i_in_valid | o_in_ready  | i_in_item  (t_in_item)
//   result  | o_out_valid| i_out_ready | o_out_item (t_out_item)
//
// Push: accept, then store write plus result load.
// Steal / drain: accept, plan and trim, then a read and an emit step per task, since the
// single store read port has registered data feeding the output register.
// A command that removes nothing goes through accept, plan, trim and a null result.
// Synchronous active-low reset clears pointers, occupancy and control; the
// task store is not cleared. A stalled output holds the sequencer in place.
module work_steal_task_deque
    import wstd_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int TASK_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_ctl_cmd ctl_cmd;
    t_dp_stat dp_stat;

    wstd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (ctl_cmd)
    );

    wstd_dp #(
        .DEPTH      (DEPTH),
        .TASK_WIDTH (TASK_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .i_cmd       (ctl_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for work_steal_task_deque.
// Queue-fed driver, clocked monitor and an in-bench deque predictor; needs wstd_pkg.
`timescale 1ns / 1ps

module tb_top;
    import wstd_pkg::*;

    localparam int QDEPTH   = 64;
    localparam int RAND_CMDS = 130;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    work_steal_task_deque u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #10 i_clk = ~i_clk;

    t_in_item    cmd_pending[$];
    t_out_item   result_q[$];
    logic [31:0] deq_store[QDEPTH];
    int          deq_front = 0;
    int          deq_held = 0;
    int          cmd_total = 0;
    int          cmd_taken = 0;
    int          err_cnt = 0;
    logic        in_fire = 1'b0;
    int          stall_left = 0;
    bit          stall_done = 1'b0;

    function automatic t_in_item make_cmd(t_mode m, logic [31:0] w, int maxc, int res);
        t_in_item c;
        c.mode       = m;
        c.task_word  = w;
        c.take_limit = 7'(maxc);
        c.keep_floor = 7'(res);
        return c;
    endfunction

    function automatic void queue_cmd(t_in_item c);
        cmd_pending = {cmd_pending, c};
    endfunction

    function automatic int rand_count();
        int k;
        k = $urandom_range(0, 7);
        if (k == 0) return 0;
        if (k == 1) return 64;
        return $urandom_range(1, 40);
    endfunction

    function automatic int rand_reserve();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 64);
        return $urandom_range(0, 12);
    endfunction

    // apply one command to the shadow deque and queue up its results
    task automatic deque_apply(t_in_item c);
        int          total;
        int          cnt;
        int          target;
        int          slot;
        logic [31:0] taken[$];
        t_out_item   r;
        total = deq_held;
        cnt = 0;
        r = '0;
        r.last = 1'b1;
        if (c.mode == MODE_PUSH) begin
            r.status = (total >= QDEPTH);
            if (total < QDEPTH) begin
                deq_store[(deq_front + total) % QDEPTH] = c.task_word;
                deq_held = total + 1;
            end
            r.occupancy = 7'(deq_held);
            result_q = {result_q, r};
        end else begin
            if (c.mode == MODE_STEAL) begin
                if (c.take_limit != 0 && total > int'(c.keep_floor)) begin
                    target = 1;
                    if (total >= STEAL_BIG) target = (total * 2) / 5;
                    else if (total >= STEAL_MID) target = total / 3;
                    if (target == 0) target = 1;
                    cnt = target;
                    if (total - int'(c.keep_floor) < cnt) cnt = total - int'(c.keep_floor);
                    if (int'(c.take_limit) < cnt) cnt = c.take_limit;
                end
                for (int i = 0; i < cnt; i++) begin
                    slot = (deq_front + deq_held - 1) % QDEPTH;
                    deq_held--;
                    taken = {taken, deq_store[slot]};
                end
            end else begin
                cnt = (c.mode == MODE_DRAIN) ? int'(c.take_limit) : total;
                if (cnt > total) cnt = total;
                for (int i = 0; i < cnt; i++) begin
                    taken = {taken, deq_store[deq_front]};
                    deq_front = (deq_front + 1) % QDEPTH;
                    deq_held--;
                end
            end
            r.occupancy = 7'(deq_held);
            if (cnt == 0) begin
                result_q = {result_q, r};
            end else begin
                for (int i = 0; i < cnt; i++) begin
                    r.item_valid  = 1'b1;
                    r.out_task    = taken[i];
                    r.last        = (i == cnt - 1);
                    r.moved_count = 7'(cnt);
                    result_q = {result_q, r};
                end
            end
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            err_cnt++;
        end
    endtask

    function automatic int send_idle_pct();
        if (cmd_taken < cmd_total / 3) return 31;
        if (cmd_taken < (cmd_total * 2) / 3) return 45;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (cmd_taken < cmd_total / 3) return 45;
        if (cmd_taken < (cmd_total * 2) / 3) return 31;
        return 0;
    endfunction

    // stimulus and end of run
    initial begin
        int kind;
        int len;
        queue_cmd(make_cmd(MODE_STEAL, $urandom, 5, 0));
        queue_cmd(make_cmd(MODE_DRAIN, $urandom, 5, 0));
        queue_cmd(make_cmd(MODE_ALL, $urandom, 0, 0));
        queue_cmd(make_cmd(MODE_PUSH, 32'h0000_0000, 0, 0));
        queue_cmd(make_cmd(MODE_PUSH, 32'hFFFF_FFFF, 64, 64));
        repeat (4) queue_cmd(make_cmd(MODE_PUSH, $urandom, 0, 0));
        queue_cmd(make_cmd(MODE_STEAL, $urandom, 0, 0));
        queue_cmd(make_cmd(MODE_DRAIN, $urandom, 0, 0));
        queue_cmd(make_cmd(MODE_STEAL, $urandom, 10, 6));
        queue_cmd(make_cmd(MODE_STEAL, $urandom, 64, 64));
        queue_cmd(make_cmd(MODE_STEAL, $urandom, 64, 0));
        repeat (5) queue_cmd(make_cmd(MODE_PUSH, $urandom, 0, 0));
        queue_cmd(make_cmd(MODE_STEAL, $urandom, 64, 0));
        queue_cmd(make_cmd(MODE_STEAL, $urandom, 2, 5));
        queue_cmd(make_cmd(MODE_DRAIN, $urandom, 2, 0));
        queue_cmd(make_cmd(MODE_DRAIN, $urandom, 64, 0));
        queue_cmd(make_cmd(MODE_PUSH, $urandom, 0, 0));
        queue_cmd(make_cmd(MODE_ALL, $urandom, 0, 0));

        // fill past full, then steal at full occupancy
        repeat (QDEPTH + 3) begin
            queue_cmd(make_cmd(MODE_PUSH, $urandom, $urandom_range(0, 64), 0));
        end
        queue_cmd(make_cmd(MODE_STEAL, $urandom, 64, 0));
        while (cmd_pending.size() < RAND_CMDS) begin
            kind = $urandom_range(0, 11);
            if (kind < 5) begin
                len = $urandom_range(1, 12);
                repeat (len) begin
                    queue_cmd(make_cmd(MODE_PUSH, $urandom, rand_count(), 0));
                end
            end else begin
                if (kind < 7)
                    queue_cmd(make_cmd(MODE_STEAL, $urandom, rand_count(),
                                       rand_reserve()));
                else if (kind < 9)
                    queue_cmd(make_cmd(MODE_DRAIN, $urandom, rand_count(),
                                       rand_reserve()));
                else if (kind == 9)
                    queue_cmd(make_cmd(MODE_ALL, $urandom, rand_count(),
                                       rand_reserve()));
                else
                    queue_cmd(make_cmd(t_mode'($urandom_range(0, 3)), $urandom,
                                       $urandom_range(0, 64),
                                       $urandom_range(0, 64)));
            end
        end
        cmd_total = cmd_pending.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(cmd_taken == cmd_total && result_q.size() == 0)) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (err_cnt == 0 && result_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // command driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (cmd_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                i_in_valid <= 1'b1;
                i_in_item  <= cmd_pending[0];
                cmd_pending.delete(0);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result sink, with one long hold-off late in the run
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (!stall_done && cmd_taken >= (cmd_total * 3) / 4) begin
            i_out_ready <= 1'b0;
            stall_left  <= 400;
            stall_done  <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
        end
    end

    // monitor: score results, then predict from the accepted command
    always @(posedge i_clk) begin : mon
        t_out_item want;
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected transaction: %p", o_out_item);
                    err_cnt++;
                end else begin
                    want = result_q[0];
                    result_q.delete(0);
                    check_field("item_valid", want.item_valid, o_out_item.item_valid);
                    check_field("out_task", want.out_task, o_out_item.out_task);
                    check_field("last", want.last, o_out_item.last);
                    check_field("moved_count", want.moved_count, o_out_item.moved_count);
                    check_field("occupancy", want.occupancy, o_out_item.occupancy);
                    check_field("status", want.status, o_out_item.status);
                end
            end
            if (i_in_valid && o_in_ready) begin
                deque_apply(i_in_item);
                cmd_taken++;
            end
        end
    end

endmodule
